/* design/longest_match_token_encoder_unit_assert.svh */
// Assertion helpers for the token encoder checker.
`ifndef LONGEST_MATCH_TOKEN_ENCODER_UNIT_ASSERT_SVH
`define LONGEST_MATCH_TOKEN_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LMTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmte check failed");

// Next-cycle implication, disabled during reset.
`define LMTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmte check failed");

`endif

/* design/lmte_pkg.sv */
`default_nettype none
package lmte_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int WORD_CHARS    = 16;
    localparam int PEND_DEPTH    = WORD_CHARS + 1;

    localparam int ENT_IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ROW_W     = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
    localparam int LEN_W     = $clog2(WORD_CHARS + 1);
    localparam int PIDX_W    = $clog2(PEND_DEPTH);
    localparam int CNT_W     = $clog2(PEND_DEPTH + 1);

    localparam logic [1:0] FUNC_TEXT = 2'd0;
    localparam logic [1:0] FUNC_CHAR = 2'd1;
    localparam logic [1:0] FUNC_WORD = 2'd2;

    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_WORD = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  entry;
        logic [3:0]  position;
        logic [7:0]  char_value;
        logic [15:0] token_code;
        logic [4:0]  word_length;
        logic        end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [15:0] token_value;
        logic        from_table;
        logic        run_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ENT_IDX_W-1:0] entry;
        logic [ROW_W-1:0]     position;
        logic [7:0]           char_value;
        logic [15:0]          token_code;
        logic [LEN_W-1:0]     word_length;
        logic                 end_of_text;
    } q_item_t;

endpackage
`default_nettype wire

/* design/longest_match_token_encoder_unit.sv */
// Longest-match token encoder.
// Input channel (item_valid/item_stall/item): text bytes and table loads, one
// transaction per item. Loads fill a 16-entry word table; text bytes are
// tokenized by maximal munch, emitting the longest matching word's code or a
// single raw byte.
// Output channel (token_valid/token_stall/token): one transaction per token;
// run_last marks the final token caused by one text byte.
// A two-deep queue sits behind the input, so items are taken while the
// matcher is busy. Loads are applied when the idle matcher pops them. A text
// byte is matched by comparing the pending bytes one at a time; each emitted
// token drops its bytes one at a time in S_DROP, then the bytes left are
// rescanned. The table text lives in a RAM with one read port, read one
// character column per cycle; a byte is read in S_RD, compared in S_CMP.
// Reset clears the table lengths (all entries unused), the pending byte count
// and the queue. When the receiver stalls, the token stays held in the output
// register and the matcher waits before issuing the next one.
`default_nettype none
module longest_match_token_encoder_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire lmte_pkg::in_item_t  item,
    output logic                     token_valid,
    input  wire logic                token_stall,
    output lmte_pkg::out_item_t      token
);
    import lmte_pkg::*;

    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    lmte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    lmte_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token)
    );

endmodule
`default_nettype wire

/* design/lmte_front.sv */
`default_nettype none
module lmte_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire lmte_pkg::in_item_t item,
    output logic                    q_valid,
    output lmte_pkg::q_item_t       q_item,
    input  wire logic               q_pop
);
    import lmte_pkg::*;

    q_item_t    fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep;
    logic       push;
    q_item_t    cls;

    always_comb
    begin
        cls             = '0;
        cls.entry       = ENT_IDX_W'(item.entry);
        cls.position    = ROW_W'(item.position);
        cls.char_value  = item.char_value;
        cls.token_code  = item.token_code;
        cls.word_length = (int'(item.word_length) > WORD_CHARS) ? LEN_W'(WORD_CHARS)
                                                                : LEN_W'(item.word_length);
        cls.end_of_text = item.end_of_text;
        keep            = 1'b0;
        case (item.func)
            FUNC_TEXT:
            begin
                cls.kind = KIND_TEXT;
                keep     = 1'b1;
            end
            FUNC_CHAR:
            begin
                cls.kind = KIND_CHAR;
                keep     = (int'(item.entry) < TABLE_ENTRIES) &&
                           (int'(item.position) < WORD_CHARS);
            end
            FUNC_WORD:
            begin
                cls.kind = KIND_WORD;
                keep     = int'(item.entry) < TABLE_ENTRIES;
            end
            default:
            begin
                cls.kind = KIND_TEXT;
                keep     = 1'b0;
            end
        endcase
    end

    assign item_stall = (cnt_reg == 2'd2);
    assign push       = item_valid && !item_stall && keep;
    assign q_valid    = (cnt_reg != 2'd0);
    assign q_item     = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

/* design/lmte_back.sv */
`default_nettype none
module lmte_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire lmte_pkg::q_item_t q_item,
    output logic                   q_pop,
    output logic                   token_valid,
    input  wire logic              token_stall,
    output lmte_pkg::out_item_t    token
);
    import lmte_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DROP   = 3'd4;

    logic [TABLE_ENTRIES-1:0][7:0] text_mem [WORD_CHARS];
    logic [TABLE_ENTRIES-1:0][7:0] rd_row_reg;

    logic [15:0]      code_reg [TABLE_ENTRIES];
    logic [LEN_W-1:0] len_reg [TABLE_ENTRIES];
    logic [7:0]       pend_reg [PEND_DEPTH];

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         c_reg, c_next;
    logic [CNT_W-1:0]         drop_reg, drop_next;
    logic [TABLE_ENTRIES-1:0] alive_reg, alive_next;
    logic                     rescan_reg, rescan_next;
    logic                     hit_reg, hit_next;
    logic                     eot_reg, eot_next;
    logic                     best_valid_reg, best_valid_next;
    logic [15:0]              best_code_reg, best_code_next;
    logic [LEN_W-1:0]         best_len_reg, best_len_next;
    logic                     hold_valid_reg, hold_valid_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                hold_reg;
    out_item_t                out_reg;

    logic                     pend_wr;
    logic                     pend_shift;
    logic                     hold_load;
    logic                     out_push;
    logic                     out_last;
    logic                     out_free;
    logic                     done;
    logic [CNT_W-1:0]         n_val;
    logic                     last;
    logic [TABLE_ENTRIES-1:0] alive_new;
    logic [TABLE_ENTRIES-1:0] full;
    logic [ENT_IDX_W-1:0]     top_idx;
    logic [15:0]              emit_value;
    logic [CNT_W-1:0]         drop_amt;

    assign n_val    = c_reg + CNT_W'(1);
    assign last     = (n_val == cnt_reg);
    assign out_free = !out_valid_reg || !token_stall;
    assign done     = (cnt_reg == '0) || (hit_reg && !eot_reg);

    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            alive_new[i] = alive_reg[i] && (rd_row_reg[i] == pend_reg[PIDX_W'(c_reg)]) &&
                           (int'(len_reg[i]) >= int'(n_val));
            full[i]      = alive_new[i] && (int'(len_reg[i]) == int'(n_val));
            if (full[i])
            begin
                top_idx = ENT_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        emit_value = best_valid_reg ? best_code_reg : {8'd0, pend_reg[0]};
        if (!best_valid_reg || best_len_reg == '0)
        begin
            drop_amt = CNT_W'(1);
        end
        else if (int'(best_len_reg) > int'(cnt_reg))
        begin
            drop_amt = cnt_reg;
        end
        else
        begin
            drop_amt = CNT_W'(best_len_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        c_next          = c_reg;
        drop_next       = drop_reg;
        alive_next      = alive_reg;
        rescan_next     = rescan_reg;
        hit_next        = hit_reg;
        eot_next        = eot_reg;
        best_valid_next = best_valid_reg;
        best_code_next  = best_code_reg;
        best_len_next   = best_len_reg;
        hold_valid_next = hold_valid_reg;
        q_pop           = 1'b0;
        pend_wr         = 1'b0;
        pend_shift      = 1'b0;
        hold_load       = 1'b0;
        out_push        = 1'b0;
        out_last        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.kind == KIND_TEXT)
                    begin
                        pend_wr     = 1'b1;
                        cnt_next    = cnt_reg + CNT_W'(1);
                        eot_next    = q_item.end_of_text;
                        rescan_next = 1'b0;
                        c_next      = '0;
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                        begin
                            alive_next[i] = (len_reg[i] != '0) &&
                                            (int'(len_reg[i]) >= int'(cnt_reg) + 1);
                        end
                        state_next  = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                alive_next = alive_new;
                if ((|full) && (rescan_reg || last))
                begin
                    best_valid_next = 1'b1;
                    best_code_next  = code_reg[top_idx];
                    best_len_next   = LEN_W'(n_val);
                end
                if (alive_new == '0)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
                else if (last)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                begin
                    c_next     = n_val;
                    state_next = S_RD;
                end
            end
            S_DECIDE:
            begin
                if (done)
                begin
                    if (!hold_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_push        = 1'b1;
                        out_last        = 1'b1;
                        hold_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else if (!hold_valid_reg || out_free)
                begin
                    out_push        = hold_valid_reg;
                    hold_load       = 1'b1;
                    hold_valid_next = 1'b1;
                    best_valid_next = 1'b0;
                    best_code_next  = '0;
                    best_len_next   = '0;
                    drop_next       = drop_amt;
                    state_next      = S_DROP;
                end
            end
            S_DROP:
            begin
                pend_shift = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                drop_next  = drop_reg - CNT_W'(1);
                if (drop_reg == CNT_W'(1))
                begin
                    c_next      = '0;
                    rescan_next = 1'b1;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        alive_next[i] = (len_reg[i] != '0);
                    end
                    state_next  = (cnt_reg == CNT_W'(1)) ? S_DECIDE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_push)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && token_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            c_reg          <= '0;
            drop_reg       <= '0;
            alive_reg      <= '0;
            rescan_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            eot_reg        <= 1'b0;
            best_valid_reg <= 1'b0;
            best_code_reg  <= '0;
            best_len_reg   <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            c_reg          <= c_next;
            drop_reg       <= drop_next;
            alive_reg      <= alive_next;
            rescan_reg     <= rescan_next;
            hit_reg        <= hit_next;
            eot_reg        <= eot_next;
            best_valid_reg <= best_valid_next;
            best_code_reg  <= best_code_next;
            best_len_reg   <= best_len_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (q_pop && q_item.kind == KIND_WORD)
            begin
                len_reg[q_item.entry] <= q_item.word_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg <= text_mem[ROW_W'(c_reg)];
        if (q_pop && q_item.kind == KIND_CHAR)
        begin
            text_mem[q_item.position][q_item.entry] <= q_item.char_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.kind == KIND_WORD)
        begin
            code_reg[q_item.entry] <= q_item.token_code;
        end
        if (pend_wr)
        begin
            pend_reg[PIDX_W'(cnt_reg)] <= q_item.char_value;
        end
        else if (pend_shift)
        begin
            for (int j = 0; j < PEND_DEPTH - 1; j++)
            begin
                pend_reg[j] <= pend_reg[j + 1];
            end
        end
        if (hold_load)
        begin
            hold_reg.token_value <= emit_value;
            hold_reg.from_table  <= best_valid_reg;
            hold_reg.run_last    <= 1'b0;
        end
        if (out_push)
        begin
            out_reg.token_value <= hold_reg.token_value;
            out_reg.from_table  <= hold_reg.from_table;
            out_reg.run_last    <= out_last;
        end
    end

    assign token_valid = out_valid_reg;
    assign token       = out_reg;

endmodule
`default_nettype wire

/* design/lmte_checker.sv */
`default_nettype none
`include "longest_match_token_encoder_unit_assert.svh"
module lmte_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_stall,
    input wire lmte_pkg::in_item_t  item,
    input wire logic                token_valid,
    input wire logic                token_stall,
    input wire lmte_pkg::out_item_t token
);
    import lmte_pkg::*;

    `LMTE_ASSERT_NXT(a_hold_valid, clk, rst_n, token_valid && token_stall, token_valid)
    `LMTE_ASSERT_NXT(a_hold_data, clk, rst_n, token_valid && token_stall, $stable(token))
    `LMTE_ASSERT_IMP(a_char_range, clk, rst_n, token_valid && !token.from_table, token.token_value[15:8] == 8'd0)
    `LMTE_ASSERT_IMP(a_reset_quiet, clk, rst_n, $rose(rst_n), !token_valid)

endmodule

bind longest_match_token_encoder_unit lmte_checker u_lmte_checker (.*);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import lmte_pkg::*;

    class token_scoreboard;
        logic [7:0]  words_text [TABLE_ENTRIES][WORD_CHARS];
        logic [15:0] words_code [TABLE_ENTRIES];
        int          words_len [TABLE_ENTRIES];
        logic [7:0]  held [$];
        bit          best_ok;
        logic [15:0] best_tok;
        int          best_len;
        out_item_t   expected_tokens [$];
        int          failures;
        int          tokens_seen;
        int          words_seen;

        function new();
            foreach (words_len[i])
                words_len[i] = 0;
            best_ok = 0;
            best_tok = 0;
            best_len = 0;
            failures = 0;
            tokens_seen = 0;
            words_seen = 0;
        endfunction

        function bit prefix_hits(int n);
            bit hit;
            bit same;
            hit = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (words_len[i] == 0 || words_len[i] < n)
                    continue;
                same = 1;
                for (int c = 0; c < n; c++)
                    if (words_text[i][c] !== held[c])
                        same = 0;
                if (!same)
                    continue;
                hit = 1;
                if (words_len[i] == n)
                begin
                    best_ok = 1;
                    best_tok = words_code[i];
                    best_len = n;
                end
            end
            return hit;
        endfunction

        function void note_item(in_item_t it);
            bit hit;
            int k;
            int d;
            out_item_t t;
            k = 0;
            case (it.func)
                FUNC_CHAR:
                    words_text[it.entry][it.position] = it.char_value;
                FUNC_WORD:
                begin
                    words_code[it.entry] = it.token_code;
                    words_len[it.entry] = (it.word_length > WORD_CHARS) ? WORD_CHARS
                                                                        : it.word_length;
                end
                FUNC_TEXT:
                begin
                    if (held.size() < PEND_DEPTH)
                        held.push_back(it.char_value);
                    hit = prefix_hits(held.size());
                    while (held.size() > 0 && k < PEND_DEPTH)
                    begin
                        if (hit && !it.end_of_text)
                            break;
                        if (best_ok)
                        begin
                            t.token_value = best_tok;
                            t.from_table = 1;
                            d = (best_len == 0) ? 1 : best_len;
                        end
                        else
                        begin
                            t.token_value = {8'h00, held[0]};
                            t.from_table = 0;
                            d = 1;
                        end
                        t.run_last = 0;
                        repeat (d)
                            if (held.size() > 0)
                                void'(held.pop_front());
                        expected_tokens.push_back(t);
                        k++;
                        best_ok = 0;
                        best_tok = 0;
                        best_len = 0;
                        hit = 1;
                        for (int n = 1; n <= held.size(); n++)
                            if (!prefix_hits(n))
                            begin
                                hit = 0;
                                break;
                            end
                    end
                    if (k > 0)
                        expected_tokens[expected_tokens.size() - 1].run_last = 1;
                end
                default: ;
            endcase
        endfunction

        function void check_token(out_item_t got);
            out_item_t want;
            tokens_seen++;
            if (got.from_table === 1'b1)
                words_seen++;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token %h", got);
                failures++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_value !== want.token_value)
            begin
                $error("token_value expected %h actual %h", want.token_value,
                       got.token_value);
                failures++;
            end
            if (got.from_table !== want.from_table)
            begin
                $error("from_table expected %b actual %b", want.from_table, got.from_table);
                failures++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last expected %b actual %b", want.run_last, got.run_last);
                failures++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      token_valid;
    logic      token_stall;
    out_item_t token;

    token_scoreboard sb;
    int  idle_cycles = 0;
    int  items_sent;
    int  flood_req = 0;
    int  flood_served = 0;
    // words used for text generation
    logic [7:0] lex [TABLE_ENTRIES][WORD_CHARS];
    int         lex_len [TABLE_ENTRIES];

    longest_match_token_encoder_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token(token)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(in_item_t it, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic load_char(int e, int p, logic [7:0] c, bit gaps);
        in_item_t it;
        it = '0;
        it.func = FUNC_CHAR;
        it.entry = 4'(e);
        it.position = 4'(p);
        it.char_value = c;
        it.token_code = 16'($urandom);
        it.word_length = 5'($urandom);
        it.end_of_text = 1'($urandom);
        send_item(it, gaps);
    endtask

    task automatic load_word(int e, logic [15:0] code, logic [4:0] len, bit gaps);
        in_item_t it;
        it = '0;
        it.func = FUNC_WORD;
        it.entry = 4'(e);
        it.token_code = code;
        it.word_length = len;
        it.position = 4'($urandom);
        it.char_value = 8'($urandom);
        it.end_of_text = 1'($urandom);
        send_item(it, gaps);
    endtask

    task automatic send_text(logic [7:0] c, bit eot, bit gaps);
        in_item_t it;
        it = '0;
        it.func = FUNC_TEXT;
        it.char_value = c;
        it.end_of_text = eot;
        it.entry = 4'($urandom);
        it.position = 4'($urandom);
        it.token_code = 16'($urandom);
        it.word_length = 5'($urandom);
        send_item(it, gaps);
    endtask

    // writes all characters first so no used entry has an unwritten character
    task automatic define_word(int e, int len, logic [15:0] code, bit gaps);
        for (int p = 0; p < WORD_CHARS; p++)
        begin
            lex[e][p] = (p < len) ? lex[e][p] : 8'h00;
            load_char(e, p, lex[e][p], gaps);
        end
        lex_len[e] = len > WORD_CHARS ? WORD_CHARS : len;
        load_word(e, code, 5'(len), gaps);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (120)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (token_valid === 1'b1 && token_stall === 1'b0 && rst_n)
            sb.check_token(token);
    end

    initial
    begin
        int g;
        token_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (flood_req != flood_served)
            begin
                flood_served++;
                token_stall <= 1'b1;
                repeat (400)
                    @(posedge clk);
            end
            else
            begin
                g = $urandom_range(0, 99) < 60 ? 0 : gap_len();
                token_stall <= (g != 0);
                repeat (g == 0 ? 1 : g)
                    @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (token_valid && !token_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int e;
        int w;
        int rounds;
        bit flood;
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        items_sent = 0;
        rounds = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, byte zero, byte 0xff, ignored func
        send_text(8'h00, 1'b0, 0);
        send_text(8'hff, 1'b1, 0);
        begin
            in_item_t it;
            it = '1;
            send_item(it, 0);
        end
        // nested words with duplicate; full length word; overlong length
        lex[0][0] = "a"; lex[0][1] = "b";
        define_word(0, 2, 16'h1111, 0);
        lex[1][0] = "a"; lex[1][1] = "b";
        define_word(1, 2, 16'h2222, 0);
        lex[2][0] = "a";
        define_word(2, 1, 16'h0000, 0);
        for (int p = 0; p < WORD_CHARS; p++)
            lex[15][p] = 8'(8'h80 + p);
        define_word(15, 31, 16'hffff, 0);
        send_text("a", 0, 0);
        send_text("b", 0, 0);
        send_text("a", 0, 0);
        send_text("c", 0, 0);
        send_text("a", 1, 0);
        for (int p = 0; p < WORD_CHARS; p++)
            send_text(8'(8'h80 + p), p == WORD_CHARS - 1, 0);
        for (int p = 0; p < WORD_CHARS - 1; p++)
            send_text(8'(8'h80 + p), 0, 0);
        send_text("z", 1, 0);
        load_word(2, 16'h0000, 5'd0, 0);
        wait_drained();

        // random table then random text, mostly built from table words
        while (items_sent < 175)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e = $urandom_range(0, TABLE_ENTRIES - 1);
                w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                             : $urandom_range(1, 4);
                for (int p = 0; p < WORD_CHARS; p++)
                    lex[e][p] = 8'($urandom_range(0, 3) == 0 ? $urandom
                                                             : "a" + $urandom_range(0, 2));
                define_word(e, w, 16'($urandom), $urandom_range(0, 3) == 0);
            end
            flood = (rounds == 0) || ($urandom_range(0, 3) == 0);
            rounds++;
            if (flood)
                flood_req++;
            repeat (15)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    e = $urandom_range(0, TABLE_ENTRIES - 1);
                    for (int p = 0; p < lex_len[e]; p++)
                        send_text(lex[e][p], 0, !flood);
                end
                else
                    send_text(8'($urandom_range(0, 1) ? $urandom : "a" + $urandom_range(0, 3)),
                              0, !flood);
            end
            send_text(8'($urandom), 1, 1);
            wait_drained();
        end
        wait_drained();
        $display("Sent %0d items; checked %0d tokens, %0d of them table words.",
                 items_sent, sb.tokens_seen, sb.words_seen);
        $display("Covered loads, ignored items, nested and duplicate words, long words, flush.");
        if (sb.failures == 0 && sb.expected_tokens.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/lmte_pkg.sv
design/lmte_front.sv
design/lmte_back.sv
design/longest_match_token_encoder_unit.sv
design/lmte_checker.sv
tb/sv/tb.sv
